>>> rtl/tcprq_pkg.sv
// ----------------------------------------------------------------------------
// tcprq_pkg: shared types and codes of the three-class run queue
// Widths, operation and status codes, and the slot entry layout used by the
// queue sequencer and the slot store.
// ----------------------------------------------------------------------------
package tcprq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned PriW       = 16;
  localparam int unsigned IdxW       = $clog2(QueueDepth);

  // Fixed field widths of the transfer payloads.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned TaskIdW = 6;
  localparam int unsigned ClassW  = 2;
  localparam int unsigned PriFieldW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  localparam logic [ModeW-1:0] ModeEnq = 2'd0;
  localparam logic [ModeW-1:0] ModeDeq = 2'd1;
  localparam logic [ModeW-1:0] ModeRem = 2'd2;

  localparam logic [ClassW-1:0] ClsRealtime    = 2'd0;
  localparam logic [ClassW-1:0] ClsInteractive = 2'd1;
  localparam logic [ClassW-1:0] ClsBatch       = 2'd2;

  localparam logic [StatusW-1:0] StatOk        = 2'd0;
  localparam logic [StatusW-1:0] StatIdle      = 2'd1;
  localparam logic [StatusW-1:0] StatNotQueued = 2'd2;
  localparam logic [StatusW-1:0] StatFullDup   = 2'd3;

  typedef struct packed {
    logic [ClassW-1:0]      cls;
    logic signed [PriW-1:0] pri;
    logic [IdxW-1:0]        rank;
  } slot_entry_t;

  typedef struct packed {
    logic [IdxW-1:0] rd_addr;
    logic            we;
    logic [IdxW-1:0] wr_addr;
    slot_entry_t     wr_entry;
    logic            set_valid;
    logic            clr_valid;
    logic [IdxW-1:0] clr_addr;
  } store_cmd_t;

endpackage

>>> rtl/tcprq_if.sv
// ----------------------------------------------------------------------------
// tcprq_if: operation and result channels of the run queue
// Valid/ready channels; a transfer happens at a clock edge with both high.
// ----------------------------------------------------------------------------
interface tcprq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [tcprq_pkg::ModeW-1:0]           mode;
  logic [tcprq_pkg::TaskIdW-1:0]         task_id;
  logic [tcprq_pkg::ClassW-1:0]          task_class;
  logic signed [tcprq_pkg::PriFieldW-1:0] task_priority;

  modport source (output valid, mode, task_id, task_class, task_priority, input ready);
  modport sink   (input valid, mode, task_id, task_class, task_priority, output ready);
endinterface

interface tcprq_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [tcprq_pkg::StatusW-1:0]          status;
  logic [tcprq_pkg::TaskIdW-1:0]          out_id;
  logic [tcprq_pkg::ClassW-1:0]           out_class;
  logic signed [tcprq_pkg::PriFieldW-1:0] out_priority;
  logic [tcprq_pkg::CountW-1:0]           realtime_count;
  logic [tcprq_pkg::CountW-1:0]           interactive_count;
  logic [tcprq_pkg::CountW-1:0]           batch_cnt;

  modport source (output valid, status, out_id, out_class, out_priority, realtime_count,
                  interactive_count, batch_cnt, input ready);
  modport sink   (input valid, status, out_id, out_class, out_priority, realtime_count,
                  interactive_count, batch_cnt, output ready);
endinterface

>>> rtl/tcprq_slot_store.sv
// ----------------------------------------------------------------------------
// tcprq_slot_store: task slot memory with per-slot queued flags
// One write port and one registered read port on the slot entries, plus a
// flip-flop queued flag per slot, cleared at reset.
// ----------------------------------------------------------------------------
module tcprq_slot_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcprq_pkg::store_cmd_t        cmd_i,
  input  logic [tcprq_pkg::IdxW-1:0]   look_addr_i,
  output logic                         look_valid_o,
  output tcprq_pkg::slot_entry_t       rd_entry_o,
  output logic                         rd_valid_o
);

  tcprq_pkg::slot_entry_t            mem [tcprq_pkg::QueueDepth];
  tcprq_pkg::slot_entry_t            rd_entry_q;
  logic [tcprq_pkg::QueueDepth-1:0]  valid_q;
  logic [tcprq_pkg::QueueDepth-1:0]  valid_d;
  logic                              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.wr_addr] <= cmd_i.wr_entry;
    end
    rd_entry_q <= mem[cmd_i.rd_addr];
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.we && cmd_i.set_valid) begin
      valid_d[cmd_i.wr_addr] = 1'b1;
    end
    if (cmd_i.clr_valid) begin
      valid_d[cmd_i.clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      rd_valid_q <= valid_q[cmd_i.rd_addr];
    end
  end

  assign look_valid_o = valid_q[look_addr_i];
  assign rd_entry_o   = rd_entry_q;
  assign rd_valid_o   = rd_valid_q;

endmodule

>>> rtl/three_class_priority_run_queue_unit.sv
// ----------------------------------------------------------------------------
// three_class_priority_run_queue_unit: three-class priority run queue
// Holds queued tasks by slot number and serves enqueue, dequeue and remove.
// ----------------------------------------------------------------------------
// One operation is taken at a time; the operation port is ready only while
// the sequencer is idle, and a finished result sits in an output register so
// the next operation can start before that result is taken. Enqueue, a
// rejected enqueue or remove and mode three go from the input transfer
// straight to the result state; remove fetches the named slot and then
// sweeps, dequeue of an empty queue only scans, and any other dequeue
// scans all QueueDepth = 64 slots and then sweeps them, because both
// walk the slot memory one slot per cycle through its single read port:
// dequeue first searches all slots for the winner with one shared comparator,
// then both renumber the age ranks of the remaining tasks in a second pass.
// A result that is still held in the output register stalls the next one.
// The queued flags are flip-flops cleared at reset, so no clearing pass
// follows reset. Results report the class counts after the operation.
// ----------------------------------------------------------------------------
module three_class_priority_run_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcprq_in_if.sink    op_i,
  tcprq_out_if.source res_o
);

  localparam int unsigned IdxW   = tcprq_pkg::IdxW;
  localparam int unsigned PriW   = tcprq_pkg::PriW;
  localparam int unsigned CountW = tcprq_pkg::CountW;
  localparam logic [IdxW:0] DepthCnt = (IdxW+1)'(tcprq_pkg::QueueDepth);

  localparam logic [2:0] StateIdle   = 3'd0;
  localparam logic [2:0] StateScan   = 3'd1;
  localparam logic [2:0] StateFetch  = 3'd2;
  localparam logic [2:0] StateSweep  = 3'd3;
  localparam logic [2:0] StateResult = 3'd4;

  // True when entry a is served before entry b.
  function automatic logic slot_before(tcprq_pkg::slot_entry_t a,
                                       tcprq_pkg::slot_entry_t b);
    logic res;
    res = 1'b0;
    if (a.cls < b.cls) begin
      res = 1'b1;
    end else if (a.cls == b.cls) begin
      if ($signed(a.pri) < $signed(b.pri)) begin
        res = 1'b1;
      end else if ($signed(a.pri) == $signed(b.pri)) begin
        res = (a.rank < b.rank);
      end
    end
    return res;
  endfunction

  logic [2:0]                    state_q, state_d;
  logic [IdxW:0]                 iss_q, iss_d;
  logic                          chk_q, chk_d;
  logic [IdxW-1:0]               chk_idx_q, chk_idx_d;
  logic                          found_q, found_d;
  logic [IdxW-1:0]               best_idx_q, best_idx_d;
  tcprq_pkg::slot_entry_t        best_q, best_d;
  logic [IdxW-1:0]               free_rank_q, free_rank_d;
  logic [tcprq_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic [IdxW-1:0]               res_id_q, res_id_d;
  logic [tcprq_pkg::ClassW-1:0]  res_cls_q, res_cls_d;
  logic signed [PriW-1:0]        res_pri_q, res_pri_d;
  logic [CountW-1:0]             cnt_rt_q, cnt_rt_d;
  logic [CountW-1:0]             cnt_ia_q, cnt_ia_d;
  logic [CountW-1:0]             cnt_bt_q, cnt_bt_d;

  logic                          out_valid_q, out_valid_d;
  logic [tcprq_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [IdxW-1:0]               out_id_q, out_id_d;
  logic [tcprq_pkg::ClassW-1:0]  out_cls_q, out_cls_d;
  logic signed [PriW-1:0]        out_pri_q, out_pri_d;
  logic [CountW-1:0]             out_rt_q, out_rt_d;
  logic [CountW-1:0]             out_ia_q, out_ia_d;
  logic [CountW-1:0]             out_bt_q, out_bt_d;

  tcprq_pkg::store_cmd_t         cmd;
  tcprq_pkg::slot_entry_t        rd_entry;
  logic                          rd_valid;
  logic                          look_valid;

  logic                          accept;
  logic [tcprq_pkg::ClassW-1:0]  cls_in;
  logic [IdxW-1:0]               id_in;
  logic                          id_ok;
  logic [CountW:0]               total;
  logic                          inc_en, dec_en;
  logic [tcprq_pkg::ClassW-1:0]  inc_cls, dec_cls;

  assign op_i.ready = (state_q == StateIdle);
  assign accept     = op_i.valid && op_i.ready;
  assign cls_in     = (op_i.task_class > tcprq_pkg::ClsBatch) ? tcprq_pkg::ClsBatch
                                                              : op_i.task_class;
  assign id_in      = IdxW'(op_i.task_id);
  assign id_ok      = (int'(op_i.task_id) < int'(tcprq_pkg::QueueDepth));
  assign total      = (CountW+1)'(cnt_rt_q) + (CountW+1)'(cnt_ia_q) + (CountW+1)'(cnt_bt_q);

  tcprq_slot_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .look_addr_i  (id_in),
    .look_valid_o (look_valid),
    .rd_entry_o   (rd_entry),
    .rd_valid_o   (rd_valid)
  );

  always_comb begin
    state_d      = state_q;
    iss_d        = iss_q;
    chk_d        = chk_q;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    free_rank_d  = free_rank_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_cls_d    = res_cls_q;
    res_pri_d    = res_pri_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_cls_d    = out_cls_q;
    out_pri_d    = out_pri_q;
    out_rt_d     = out_rt_q;
    out_ia_d     = out_ia_q;
    out_bt_d     = out_bt_q;
    cmd          = '0;
    cmd.rd_addr  = iss_q[IdxW-1:0];
    inc_en       = 1'b0;
    dec_en       = 1'b0;
    inc_cls      = cls_in;
    dec_cls      = rd_entry.cls;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    // Scan and sweep both walk the slots: one read issued per cycle, checked
    // in the next cycle, when the registered read data arrives.
    if (state_q == StateScan || state_q == StateSweep) begin
      if (iss_q != DepthCnt) begin
        cmd.rd_addr = iss_q[IdxW-1:0];
        iss_d       = iss_q + 1'b1;
        chk_d       = 1'b1;
        chk_idx_d   = iss_q[IdxW-1:0];
      end else begin
        chk_d = 1'b0;
      end
    end

    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          res_status_d = tcprq_pkg::StatOk;
          res_id_d     = '0;
          res_cls_d    = '0;
          res_pri_d    = '0;
          state_d      = StateResult;
          unique case (op_i.mode)
            tcprq_pkg::ModeEnq: begin
              if (!id_ok || look_valid || total >= (CountW+1)'(tcprq_pkg::QueueDepth)) begin
                res_status_d = tcprq_pkg::StatFullDup;
              end else begin
                cmd.we            = 1'b1;
                cmd.set_valid     = 1'b1;
                cmd.wr_addr       = id_in;
                cmd.wr_entry.cls  = cls_in;
                cmd.wr_entry.pri  = op_i.task_priority[PriW-1:0];
                cmd.wr_entry.rank = total[IdxW-1:0];
                inc_en            = 1'b1;
              end
            end
            tcprq_pkg::ModeDeq: begin
              iss_d   = '0;
              chk_d   = 1'b0;
              found_d = 1'b0;
              state_d = StateScan;
            end
            tcprq_pkg::ModeRem: begin
              if (!id_ok || !look_valid) begin
                res_status_d = tcprq_pkg::StatNotQueued;
              end else begin
                cmd.rd_addr = id_in;
                chk_idx_d   = id_in;
                state_d     = StateFetch;
              end
            end
            default: begin
              res_status_d = tcprq_pkg::StatNotQueued;
            end
          endcase
        end
      end

      StateScan: begin
        if (chk_q && rd_valid && (!found_q || slot_before(rd_entry, best_q))) begin
          found_d    = 1'b1;
          best_d     = rd_entry;
          best_idx_d = chk_idx_q;
        end
        if (iss_q == DepthCnt && !chk_q) begin
          if (found_q) begin
            res_id_d      = best_idx_q;
            res_cls_d     = best_q.cls;
            res_pri_d     = best_q.pri;
            cmd.clr_valid = 1'b1;
            cmd.clr_addr  = best_idx_q;
            dec_en        = 1'b1;
            dec_cls       = best_q.cls;
            free_rank_d   = best_q.rank;
            iss_d         = '0;
            state_d       = StateSweep;
          end else begin
            res_status_d = tcprq_pkg::StatIdle;
            state_d      = StateResult;
          end
        end
      end

      StateFetch: begin
        cmd.clr_valid = 1'b1;
        cmd.clr_addr  = chk_idx_q;
        dec_en        = 1'b1;
        dec_cls       = rd_entry.cls;
        free_rank_d   = rd_entry.rank;
        iss_d         = '0;
        chk_d         = 1'b0;
        state_d       = StateSweep;
      end

      StateSweep: begin
        // Tasks that arrived after the freed one move up one age rank.
        if (chk_q && rd_valid && rd_entry.rank > free_rank_q) begin
          cmd.we            = 1'b1;
          cmd.wr_addr       = chk_idx_q;
          cmd.wr_entry      = rd_entry;
          cmd.wr_entry.rank = rd_entry.rank - 1'b1;
        end
        if (iss_q == DepthCnt && !chk_q) begin
          state_d = StateResult;
        end
      end

      StateResult: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_cls_d    = res_cls_q;
          out_pri_d    = res_pri_q;
          out_rt_d     = cnt_rt_q;
          out_ia_d     = cnt_ia_q;
          out_bt_d     = cnt_bt_q;
          state_d      = StateIdle;
        end
      end

      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_comb begin
    cnt_rt_d = cnt_rt_q;
    cnt_ia_d = cnt_ia_q;
    cnt_bt_d = cnt_bt_q;
    if (inc_en) begin
      case (inc_cls)
        tcprq_pkg::ClsRealtime:    cnt_rt_d = cnt_rt_q + 1'b1;
        tcprq_pkg::ClsInteractive: cnt_ia_d = cnt_ia_q + 1'b1;
        default:                   cnt_bt_d = cnt_bt_q + 1'b1;
      endcase
    end
    if (dec_en) begin
      case (dec_cls)
        tcprq_pkg::ClsRealtime: begin
          if (cnt_rt_q != '0) cnt_rt_d = cnt_rt_q - 1'b1;
        end
        tcprq_pkg::ClsInteractive: begin
          if (cnt_ia_q != '0) cnt_ia_d = cnt_ia_q - 1'b1;
        end
        default: begin
          if (cnt_bt_q != '0) cnt_bt_d = cnt_bt_q - 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      iss_q       <= '0;
      chk_q       <= 1'b0;
      found_q     <= 1'b0;
      cnt_rt_q    <= '0;
      cnt_ia_q    <= '0;
      cnt_bt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      chk_q       <= chk_d;
      found_q     <= found_d;
      cnt_rt_q    <= cnt_rt_d;
      cnt_ia_q    <= cnt_ia_d;
      cnt_bt_q    <= cnt_bt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    free_rank_q  <= free_rank_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_cls_q    <= res_cls_d;
    res_pri_q    <= res_pri_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_cls_q    <= out_cls_d;
    out_pri_q    <= out_pri_d;
    out_rt_q     <= out_rt_d;
    out_ia_q     <= out_ia_d;
    out_bt_q     <= out_bt_d;
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.status            = out_status_q;
  assign res_o.out_id            = tcprq_pkg::TaskIdW'(out_id_q);
  assign res_o.out_class         = out_cls_q;
  assign res_o.out_priority      = tcprq_pkg::PriFieldW'(out_pri_q);
  assign res_o.realtime_count    = out_rt_q;
  assign res_o.interactive_count = out_ia_q;
  assign res_o.batch_cnt         = out_bt_q;

endmodule

>>> rtl/tcprq_checker.sv
// ----------------------------------------------------------------------------
// tcprq_checker: port-level checks of the run queue
// Watches the operation and result channels of the top level.
// ----------------------------------------------------------------------------
module tcprq_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic [tcprq_pkg::StatusW-1:0]          status_i,
  input logic [tcprq_pkg::TaskIdW-1:0]          out_id_i,
  input logic [tcprq_pkg::ClassW-1:0]           out_class_i,
  input logic signed [tcprq_pkg::PriFieldW-1:0] out_priority_i,
  input logic [tcprq_pkg::CountW-1:0]           rt_count_i,
  input logic [tcprq_pkg::CountW-1:0]           ia_count_i,
  input logic [tcprq_pkg::CountW-1:0]           bt_count_i
);

  logic [tcprq_pkg::CountW+1:0] count_sum;

  assign count_sum = (tcprq_pkg::CountW+2)'(rt_count_i) + (tcprq_pkg::CountW+2)'(ia_count_i)
                   + (tcprq_pkg::CountW+2)'(bt_count_i);

  // Only one operation is in flight: the port drops ready after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("operation port stayed ready after a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_sum <= (tcprq_pkg::CountW+2)'(tcprq_pkg::QueueDepth))
    else $error("class counts exceed the queue depth");

  // An idle answer means every class was empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == tcprq_pkg::StatIdle |->
      rt_count_i == '0 && ia_count_i == '0 && bt_count_i == '0)
    else $error("idle reported while tasks are queued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != tcprq_pkg::StatOk |->
      out_id_i == '0 && out_class_i == '0 && out_priority_i == '0)
    else $error("task fields set on a failed operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(out_id_i))
    else $error("stalled result changed");

endmodule

bind three_class_priority_run_queue_unit tcprq_checker u_tcprq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (op_i.valid),
  .in_ready_i     (op_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .status_i       (res_o.status),
  .out_id_i       (res_o.out_id),
  .out_class_i    (res_o.out_class),
  .out_priority_i (res_o.out_priority),
  .rt_count_i     (res_o.realtime_count),
  .ia_count_i     (res_o.interactive_count),
  .bt_count_i     (res_o.batch_cnt)
);
